// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, character codes and per-byte update functions for the
// command sentence parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] MIN_LINE_LEN = 8'd10;
  localparam logic [7:0] MAX_LEN_RST  = 8'd200;
  localparam logic [7:0] LEN_SAT      = 8'hFF;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_SHORT     = 2'd1,
    ST_CHECKSUM  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    PH_START = 11'b000_0000_0001,
    PH_C     = 11'b000_0000_0010,
    PH_M     = 11'b000_0000_0100,
    PH_D     = 11'b000_0000_1000,
    PH_COMMA = 11'b000_0001_0000,
    PH_ID0   = 11'b000_0010_0000,
    PH_ID    = 11'b000_0100_0000,
    PH_PAR0  = 11'b000_1000_0000,
    PH_PAR   = 11'b001_0000_0000,
    PH_OK    = 11'b010_0000_0000,
    PH_BAD   = 11'b100_0000_0000
  } phase_e;

  // Everything that describes the line being assembled.
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] xsum;
    phase_e     phase;
    logic       star;
    logic [7:0] esum;
    logic [7:0] id;
    logic [7:0] par;
    logic       dollar;
    logic       sum_end;
  } line_t;

  localparam line_t LINE_CLEAR = '{
    len: 8'd0, xsum: 8'd0, phase: PH_START, star: 1'b0, esum: 8'd0,
    id: 8'd0, par: 8'd0, dollar: 1'b0, sum_end: 1'b0
  };

  typedef struct packed {
    status_e    status;
    logic [7:0] id;
    logic [7:0] par;
  } result_t;

  // Returns {is_digit, value}.
  function automatic logic [4:0] hex_f(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Adds one content byte to the line, or clears the line once its length passes max_len.
  function automatic line_t commit_f(input line_t s, input logic [7:0] b,
                                     input logic [7:0] max_len);
    line_t      n;
    logic [4:0] h;
    logic       first;
    n     = s;
    h     = hex_f(b);
    first = (s.phase == PH_START);

    if (!s.star) begin
      if (b == CH_STAR) begin
        n.star = 1'b1;
      end else if (!first) begin
        n.xsum = s.xsum ^ b;
      end
    end else if (!s.sum_end) begin
      if (h[4]) begin
        n.esum = {s.esum[3:0], h[3:0]};
      end else begin
        n.sum_end = 1'b1;
      end
    end

    case (s.phase)
      PH_START: begin
        if (b == CH_DOLLAR) begin
          n.dollar = 1'b1;
          n.phase  = PH_C;
        end else begin
          n.phase = PH_BAD;
        end
      end
      PH_C:     n.phase = (b == CH_C) ? PH_M : PH_BAD;
      PH_M:     n.phase = (b == CH_M) ? PH_D : PH_BAD;
      PH_D:     n.phase = (b == CH_D) ? PH_COMMA : PH_BAD;
      PH_COMMA: n.phase = (b == CH_COMMA) ? PH_ID0 : PH_BAD;
      PH_ID0: begin
        if (h[4]) begin
          n.id    = {4'd0, h[3:0]};
          n.phase = PH_ID;
        end else begin
          n.phase = PH_BAD;
        end
      end
      PH_ID: begin
        if (h[4]) begin
          n.id = {s.id[3:0], h[3:0]};
        end else begin
          n.phase = (b == CH_COMMA) ? PH_PAR0 : PH_OK;
        end
      end
      PH_PAR0: begin
        if (h[4]) begin
          n.par   = {4'd0, h[3:0]};
          n.phase = PH_PAR;
        end else begin
          n.phase = PH_OK;
        end
      end
      PH_PAR: begin
        if (h[4]) begin
          n.par = {s.par[3:0], h[3:0]};
        end else begin
          n.phase = PH_OK;
        end
      end
      PH_OK:   n.phase = PH_OK;
      default: n.phase = PH_BAD;
    endcase

    if (s.len != LEN_SAT) begin
      n.len = s.len + 8'd1;
    end
    if (n.len > max_len) begin
      n = LINE_CLEAR;
    end
    return n;
  endfunction

  // Verdict on a line that has just been terminated.
  function automatic result_t finish_f(input line_t s);
    result_t r;
    r.status = ST_MALFORMED;
    r.id     = 8'd0;
    r.par    = 8'd0;
    if (s.len < MIN_LINE_LEN || !s.dollar) begin
      r.status = ST_SHORT;
    end else if (!s.star || s.xsum != s.esum) begin
      r.status = ST_CHECKSUM;
    end else if (s.phase == PH_ID || s.phase == PH_PAR0 ||
                 s.phase == PH_PAR || s.phase == PH_OK) begin
      r.status = ST_ACCEPTED;
      r.id     = s.id;
      r.par    = s.par;
    end
    return r;
  endfunction

endpackage

// ===== rtl/command_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// command_sentence_parser
// Byte-serial parser for "$CMD,<id>[,<param>]*<checksum>" lines ended by
// CR LF, giving one verdict beat per line.
// ----------------------------------------------------------------------------
// Timing: the LF beat is captured in the input register, and the verdict beat is
//   registered when that beat advances, which waits while an earlier result is stalled.
// Throughput: one byte beat per cycle, except while a line-ending LF waits on a stalled
//   result; the line state update is a single pass of short logic between the input
//   register and the line registers. Reset: rst_ni clears all line state, the pending
//   CR and both valid flags, and sets max_len_q to 200; no clearing pass is needed.
module command_sentence_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [7:0]           command_id_o,
  output logic [7:0]           parameter_res_o
);
  import csp_pkg::*;

  // Configuration register.
  logic [7:0] max_len_q;

  // Input register: the byte beat waiting to be folded into the line.
  logic       in_valid_q;
  logic [7:0] byte_q;

  // Line state and the CR held back until we know whether LF follows.
  line_t      line_q, line_d;
  logic       pcr_q, pcr_d;

  // Result register.
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic       ends_line;
  logic       advance;
  line_t      after_cr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // A held CR followed by LF terminates the line; only that case needs room
  // in the result register. Every other byte just updates the line state,
  // so the input register drains even while a result is stalled.
  assign ends_line = pcr_q && (byte_q == CH_LF);
  assign advance   = in_valid_q && (!ends_line || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    line_d   = line_q;
    pcr_d    = pcr_q;
    res_d    = finish_f(line_q);
    after_cr = pcr_q ? commit_f(line_q, CH_CR, max_len_q) : line_q;
    if (ends_line) begin
      line_d = LINE_CLEAR;
      pcr_d  = 1'b0;
    end else if (byte_q == CH_CR) begin
      // A CR that was not followed by LF counts as content; the new CR is
      // held in turn.
      line_d = after_cr;
      pcr_d  = 1'b1;
    end else begin
      line_d = commit_f(after_cr, byte_q, max_len_q);
      pcr_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      line_q      <= LINE_CLEAR;
      pcr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        line_q <= line_d;
        pcr_q  <= pcr_d;
      end
      if (advance && ends_line) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= rx_byte_i;
    end
    if (advance && ends_line) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign command_id_o    = res_q.id;
  assign parameter_res_o = res_q.par;

endmodule

// ===== rtl/csp_checker.sv =====
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the command sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
module csp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] command_id_o,
  input logic [7:0] parameter_res_o
);
  import csp_pkg::*;

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(command_id_o) && $stable(parameter_res_o))
    else $error("result payload changed while stalled");

  // Rejected lines carry no id or parameter.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_ACCEPTED |->
      command_id_o == 8'd0 && parameter_res_o == 8'd0)
    else $error("rejected line carries id or parameter");

  // A new result must be traced back to an accepted LF beat on the input port.
  a_rise_after_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && rx_byte_i == CH_LF, 2))
    else $error("result beat without a terminating LF");

endmodule

bind command_sentence_parser csp_checker u_csp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .command_id_o    (command_id_o),
  .parameter_res_o (parameter_res_o)
);
